// File: rtl/core/mlp_sgd_backprop_trainer_assert.svh
// Assertion macros for the perceptron trainer.
// Expands to nothing when SYNTHESIS is defined; no other dependencies.
`ifndef MLP_SGD_BACKPROP_TRAINER_ASSERT_SVH
`define MLP_SGD_BACKPROP_TRAINER_ASSERT_SVH
`ifndef SYNTHESIS
`define MLP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlp assertion failed");
`define MLP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlp assertion failed");
`else
`define MLP_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MLP_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/core/mlp_pkg.sv
// Shared constants, types and the sigmoid table for the perceptron trainer.
// No dependencies.
`default_nettype none
package mlp_pkg;

   localparam int HIDDEN_NODES = 4;
   localparam int STORE_DEPTH  = 4 * HIDDEN_NODES + 1;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int J_W          = (HIDDEN_NODES > 1) ? $clog2(HIDDEN_NODES) : 1;

   localparam int OFS_IN_B = HIDDEN_NODES;
   localparam int OFS_OUT  = 2 * HIDDEN_NODES;
   localparam int OFS_HB   = 3 * HIDDEN_NODES;
   localparam int OFS_OB   = 4 * HIDDEN_NODES;

   localparam int ACT_W   = 13;
   localparam int W_W     = 20;
   localparam int LR_W    = 13;
   localparam int TYPE_W  = 2;
   localparam int WIDX_W  = 5;
   localparam int ACC_W   = 40;
   localparam int Z_W     = ACC_W - 12 + 1;
   localparam int MA_W    = 32;
   localparam int MB_W    = 21;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int DS_W    = 11;
   localparam int DOUT_W  = 12;
   localparam int DH_W    = 17;
   localparam int SUM_W   = 24;
   localparam int DLR_W   = 32;
   localparam int CSR_AW  = 3;

   localparam logic [ACT_W-1:0] Q_ONE = 13'd4096;
   localparam int W_MAX = 524287;
   localparam int W_MIN = -524288;

   localparam logic [TYPE_W-1:0] REQ_INFER = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_TRAIN = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RSVD  = 2'd3;

   localparam logic CSR_LEARN_RATE = 1'b0;

   localparam int SIG_DEPTH = 256;
   localparam int SIG_IDX_W = $clog2(SIG_DEPTH);
   localparam longint unsigned E_INV_Q30 = 64'd395007542;

   typedef enum logic [4:0] {
      ST_IDLE, ST_HID_W0, ST_HID_W1, ST_HID_B, ST_OUT_W, ST_OUT_B,
      ST_DO1, ST_DO2, ST_DH0, ST_DH1, ST_DH2,
      ST_OLR, ST_OB_UPD, ST_OW_UPD,
      ST_HLR, ST_HB_UPD, ST_HWA_UPD, ST_HWB_UPD, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_HW0, OP_HW1, OP_HB, OP_OW, OP_OB,
      OP_DO1, OP_DO2, OP_DH0, OP_DH1, OP_DH2,
      OP_LR_O, OP_LR_H, OP_UB, OP_UW_H, OP_UW_A, OP_UW_B
   } op_type;

   typedef logic [ACT_W-1:0] sig_tab_type [SIG_DEPTH];

   // shift-subtract quotient, used only while building the table
   function automatic longint unsigned udiv_f(input longint unsigned num,
                                              input longint unsigned dvs);
      longint unsigned q, r;
      begin
         q = '0;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= dvs) begin
               r    = r - dvs;
               q[b] = 1'b1;
            end
         end
         return q;
      end
   endfunction

   // sigmoid at Q8.12 point x, via a 13-term series for exp(-frac)
   // and repeated scaling by 1/e for the integer part
   function automatic logic [ACT_W-1:0] sig_point_f(input longint x);
      longint unsigned t, n, f, term, e, den, k, q;
      longint sum;
      begin
         t    = (x < 0) ? longint'(-x) : longint'(x);
         n    = t >> 12;
         f    = t & 64'd4095;
         term = 64'd1 << 30;
         sum  = longint'(64'd1 << 30);
         for (k = 1; k <= 12; k++) begin
            term = udiv_f((term * f) >> 12, k);
            if (k[0]) sum = sum - longint'(term);
            else      sum = sum + longint'(term);
         end
         e = longint'(sum);
         for (k = 0; k < n; k++) e = (e * E_INV_Q30) >> 30;
         den = (64'd1 << 30) + e;
         if (x >= 0) q = udiv_f((64'd4096 << 30) + (den >> 1), den);
         else        q = udiv_f(64'd4096 * e + (den >> 1), den);
         return q[ACT_W-1:0];
      end
   endfunction

   function automatic sig_tab_type sig_table_f();
      sig_tab_type tab;
      begin
         for (int i = 0; i < SIG_DEPTH; i++)
            tab[i] = sig_point_f(-64'sd32768 +
                        longint'(((64'd2 * i + 64'd1) * 64'd32768) >> SIG_IDX_W));
         return tab;
      end
   endfunction

   localparam sig_tab_type SIG_TABLE = sig_table_f();

endpackage
`default_nettype wire

// File: rtl/core/mlp_if.sv
// Request and response channel interfaces of the perceptron trainer.
// Depends on mlp_pkg for field widths.
`default_nettype none
interface mlp_req_if;
   logic                               valid;
   logic                               ready;
   logic        [mlp_pkg::TYPE_W-1:0]  req_type;
   logic        [mlp_pkg::ACT_W-1:0]   in_a;
   logic        [mlp_pkg::ACT_W-1:0]   in_b;
   logic        [mlp_pkg::ACT_W-1:0]   target;
   logic        [mlp_pkg::WIDX_W-1:0]  weight_index;
   logic signed [mlp_pkg::W_W-1:0]     weight_value;

   modport source(output valid, req_type, in_a, in_b, target, weight_index,
                  weight_value, input ready);
   modport sink(input valid, req_type, in_a, in_b, target, weight_index,
                weight_value, output ready);
endinterface

interface mlp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [mlp_pkg::ACT_W-1:0]  net_output;
   logic                       saturated;

   modport source(output valid, net_output, saturated, input ready);
   modport sink(input valid, net_output, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/core/mlp_sig.sv
// Sigmoid lookup: clamps a pre-activation to -8..8 and reads the table.
// Depends on mlp_pkg.
`default_nettype none
module mlp_sig (
   input  logic signed [mlp_pkg::Z_W-1:0]   z,
   output logic        [mlp_pkg::ACT_W-1:0] act
);
   logic signed [15:0]                  zc;
   logic [15:0]                         zu;
   logic [31:0]                         scaled;
   logic [mlp_pkg::SIG_IDX_W-1:0]       idx;

   always_comb begin
      if (z < -32768)     zc = 16'sh8000;
      else if (z > 32767) zc = 16'sh7fff;
      else                zc = z[15:0];
      zu     = zc ^ 16'h8000;
      scaled = 32'(zu) * 32'(mlp_pkg::SIG_DEPTH);
      idx    = scaled[16 +: mlp_pkg::SIG_IDX_W];
      act    = mlp_pkg::SIG_TABLE[idx];
   end
endmodule
`default_nettype wire

// File: rtl/core/mlp_sgd_backprop_trainer.sv
// One item at a time: the single shared multiplier is fed from the weight RAM and the
// pipeline drains at each data dependency. A finished result waits in the output
// register while the next item is taken. Reset (synchronous) clears control, the
// weight valid bits (store reads as zero) and learn_rate to 410.
`default_nettype none
`include "mlp_sgd_backprop_trainer_assert.svh"
module mlp_sgd_backprop_trainer (
   input  logic                          clock,
   input  logic                          reset,
   mlp_req_if.sink                       req_bus,
   mlp_rsp_if.source                     rsp_bus,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mlp_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   localparam int H = mlp_pkg::HIDDEN_NODES;

   mlp_pkg::state_type state_ff, state_in;
   logic [mlp_pkg::J_W-1:0] j_ff, j_in;
   logic j_last, pipe_busy, issue_go, req_acc, rsp_free, res_load;

   mlp_pkg::op_type               iss_op;
   logic [mlp_pkg::ADDR_W-1:0]    iss_addr;
   logic                          iss_bar;

   // item registers
   logic [mlp_pkg::TYPE_W-1:0] type_ff;
   logic [mlp_pkg::ACT_W-1:0]  xa_ff, xb_ff, tgt_ff;
   logic [mlp_pkg::LR_W-1:0]   lr_ff, lr_c;

   // weight RAM
   logic signed [mlp_pkg::W_W-1:0] mem [mlp_pkg::STORE_DEPTH];
   logic [mlp_pkg::STORE_DEPTH-1:0] vld_ff;
   logic signed [mlp_pkg::W_W-1:0] rd_ff, w1;
   logic                           rdv_ff;
   logic                           wr_en;
   logic [mlp_pkg::ADDR_W-1:0]     wr_addr;
   logic signed [mlp_pkg::W_W-1:0] wr_data;

   // pipeline
   logic                           s1_vld_ff, s2_vld_ff;
   mlp_pkg::op_type                s1_op_ff, s2_op_ff;
   logic [mlp_pkg::J_W-1:0]        s1_j_ff, s2_j_ff;
   logic [mlp_pkg::ADDR_W-1:0]     s1_addr_ff, s2_addr_ff;
   logic signed [mlp_pkg::W_W-1:0] s2_w_ff;
   logic signed [mlp_pkg::MA_W-1:0] mul_a;
   logic signed [mlp_pkg::MB_W-1:0] mul_b;
   logic signed [mlp_pkg::PROD_W-1:0] prod_in, prod_ff, prod_sh12, prod_sh24;

   // datapath state
   logic signed [mlp_pkg::ACC_W-1:0]  acc_ff, acc_sh;
   logic [mlp_pkg::ACT_W-1:0]         h_ff [H];
   logic [mlp_pkg::ACT_W-1:0]         out_ff, sig_act;
   logic [mlp_pkg::DS_W-1:0]          dso_ff, dsh_ff;
   logic signed [mlp_pkg::DOUT_W-1:0] dout_ff;
   logic signed [31:0]                tmp_ff;
   logic signed [mlp_pkg::DH_W-1:0]   dhid_ff [H];
   logic signed [mlp_pkg::DLR_W-1:0]  dlr_ff, dlr_sh;
   logic signed [mlp_pkg::ACT_W:0]    err;
   logic signed [mlp_pkg::Z_W-1:0]    z;
   logic signed [mlp_pkg::SUM_W-1:0]  step, wsum;
   logic signed [mlp_pkg::W_W-1:0]    new_w;
   logic                              clip, upd;
   logic                              sat_ff;

   logic                      rsp_vld_ff;
   logic [mlp_pkg::ACT_W-1:0] rsp_out_ff;
   logic                      rsp_sat_ff;

   // ---------------- handshakes and config ----------------
   assign req_bus.ready = (state_ff == mlp_pkg::ST_IDLE);
   assign req_acc       = req_bus.valid && (state_ff == mlp_pkg::ST_IDLE);
   assign rsp_free      = !rsp_vld_ff || rsp_bus.ready;
   assign pipe_busy     = s1_vld_ff || s2_vld_ff;
   assign j_last        = (j_ff == mlp_pkg::J_W'(H - 1));
   assign res_load      = (state_ff == mlp_pkg::ST_DONE) && !pipe_busy && rsp_free;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mlp_pkg::CSR_LEARN_RATE) ? 32'(lr_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= mlp_pkg::LR_W'(410);
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == mlp_pkg::CSR_LEARN_RATE) begin
         lr_ff <= csr_pwdata[mlp_pkg::LR_W-1:0];
      end
   end
   assign lr_c = (lr_ff > mlp_pkg::Q_ONE) ? mlp_pkg::Q_ONE : lr_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      case (state_ff)
         mlp_pkg::ST_IDLE: begin
            if (req_acc) begin
               j_in = '0;
               if (req_bus.req_type == mlp_pkg::REQ_INFER ||
                   req_bus.req_type == mlp_pkg::REQ_TRAIN) state_in = mlp_pkg::ST_HID_W0;
               else state_in = mlp_pkg::ST_DONE;
            end
         end
         mlp_pkg::ST_HID_W0: if (issue_go) state_in = mlp_pkg::ST_HID_W1;
         mlp_pkg::ST_HID_W1: if (issue_go) state_in = mlp_pkg::ST_HID_B;
         mlp_pkg::ST_HID_B: begin
            if (issue_go) begin
               if (j_last) begin
                  state_in = mlp_pkg::ST_OUT_W;
                  j_in     = '0;
               end else begin
                  state_in = mlp_pkg::ST_HID_W0;
                  j_in     = mlp_pkg::J_W'(j_ff + 1'b1);
               end
            end
         end
         mlp_pkg::ST_OUT_W: begin
            if (issue_go) begin
               if (j_last) state_in = mlp_pkg::ST_OUT_B;
               else j_in = mlp_pkg::J_W'(j_ff + 1'b1);
            end
         end
         mlp_pkg::ST_OUT_B: begin
            if (issue_go) begin
               state_in = (type_ff == mlp_pkg::REQ_TRAIN) ? mlp_pkg::ST_DO1 : mlp_pkg::ST_DONE;
            end
         end
         mlp_pkg::ST_DO1: if (issue_go) state_in = mlp_pkg::ST_DO2;
         mlp_pkg::ST_DO2: begin
            if (issue_go) begin
               state_in = mlp_pkg::ST_DH0;
               j_in     = '0;
            end
         end
         mlp_pkg::ST_DH0: if (issue_go) state_in = mlp_pkg::ST_DH1;
         mlp_pkg::ST_DH1: if (issue_go) state_in = mlp_pkg::ST_DH2;
         mlp_pkg::ST_DH2: begin
            if (issue_go) begin
               if (j_last) begin
                  state_in = mlp_pkg::ST_OLR;
               end else begin
                  state_in = mlp_pkg::ST_DH0;
                  j_in     = mlp_pkg::J_W'(j_ff + 1'b1);
               end
            end
         end
         mlp_pkg::ST_OLR: if (issue_go) state_in = mlp_pkg::ST_OB_UPD;
         mlp_pkg::ST_OB_UPD: begin
            if (issue_go) begin
               state_in = mlp_pkg::ST_OW_UPD;
               j_in     = '0;
            end
         end
         mlp_pkg::ST_OW_UPD: begin
            if (issue_go) begin
               if (j_last) begin
                  state_in = mlp_pkg::ST_HLR;
                  j_in     = '0;
               end else begin
                  j_in = mlp_pkg::J_W'(j_ff + 1'b1);
               end
            end
         end
         mlp_pkg::ST_HLR:     if (issue_go) state_in = mlp_pkg::ST_HB_UPD;
         mlp_pkg::ST_HB_UPD:  if (issue_go) state_in = mlp_pkg::ST_HWA_UPD;
         mlp_pkg::ST_HWA_UPD: if (issue_go) state_in = mlp_pkg::ST_HWB_UPD;
         mlp_pkg::ST_HWB_UPD: begin
            if (issue_go) begin
               if (j_last) begin
                  state_in = mlp_pkg::ST_DONE;
               end else begin
                  state_in = mlp_pkg::ST_HLR;
                  j_in     = mlp_pkg::J_W'(j_ff + 1'b1);
               end
            end
         end
         mlp_pkg::ST_DONE: if (res_load) state_in = mlp_pkg::ST_IDLE;
         default: state_in = mlp_pkg::ST_IDLE;
      endcase
   end

   // op issued per state; a barrier op waits for the pipeline to drain
   always_comb begin
      iss_op   = mlp_pkg::OP_NONE;
      iss_addr = '0;
      iss_bar  = 1'b0;
      case (state_ff)
         mlp_pkg::ST_HID_W0: begin
            iss_op   = mlp_pkg::OP_HW0;
            iss_addr = mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_HID_W1: begin
            iss_op   = mlp_pkg::OP_HW1;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_IN_B) + mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_HID_B: begin
            iss_op   = mlp_pkg::OP_HB;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_HB) + mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_OUT_W: begin
            iss_op   = mlp_pkg::OP_OW;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_OUT) + mlp_pkg::ADDR_W'(j_ff);
            iss_bar  = (j_ff == '0);  // all hidden activations written first
         end
         mlp_pkg::ST_OUT_B: begin
            iss_op   = mlp_pkg::OP_OB;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_OB);
         end
         mlp_pkg::ST_DO1: begin
            iss_op  = mlp_pkg::OP_DO1;
            iss_bar = 1'b1;
         end
         mlp_pkg::ST_DO2: begin
            iss_op  = mlp_pkg::OP_DO2;
            iss_bar = 1'b1;
         end
         mlp_pkg::ST_DH0: iss_op = mlp_pkg::OP_DH0;
         mlp_pkg::ST_DH1: begin
            iss_op   = mlp_pkg::OP_DH1;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_OUT) + mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_DH2: begin
            iss_op  = mlp_pkg::OP_DH2;
            iss_bar = 1'b1;
         end
         mlp_pkg::ST_OLR: begin
            iss_op  = mlp_pkg::OP_LR_O;
            iss_bar = 1'b1;
         end
         mlp_pkg::ST_OB_UPD: begin
            iss_op   = mlp_pkg::OP_UB;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_OB);
            iss_bar  = 1'b1;
         end
         mlp_pkg::ST_OW_UPD: begin
            iss_op   = mlp_pkg::OP_UW_H;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_OUT) + mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_HLR: begin
            iss_op  = mlp_pkg::OP_LR_H;
            iss_bar = 1'b1;
         end
         mlp_pkg::ST_HB_UPD: begin
            iss_op   = mlp_pkg::OP_UB;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_HB) + mlp_pkg::ADDR_W'(j_ff);
            iss_bar  = 1'b1;
         end
         mlp_pkg::ST_HWA_UPD: begin
            iss_op   = mlp_pkg::OP_UW_A;
            iss_addr = mlp_pkg::ADDR_W'(j_ff);
         end
         mlp_pkg::ST_HWB_UPD: begin
            iss_op   = mlp_pkg::OP_UW_B;
            iss_addr = mlp_pkg::ADDR_W'(mlp_pkg::OFS_IN_B) + mlp_pkg::ADDR_W'(j_ff);
         end
         default: ;
      endcase
   end

   assign issue_go = (iss_op != mlp_pkg::OP_NONE) && !(iss_bar && pipe_busy);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mlp_pkg::ST_IDLE;
         j_ff      <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         j_ff      <= j_in;
         s1_vld_ff <= issue_go;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         type_ff <= req_bus.req_type;
         xa_ff   <= (req_bus.in_a > mlp_pkg::Q_ONE) ? mlp_pkg::Q_ONE : req_bus.in_a;
         xb_ff   <= (req_bus.in_b > mlp_pkg::Q_ONE) ? mlp_pkg::Q_ONE : req_bus.in_b;
         tgt_ff  <= (req_bus.target > mlp_pkg::Q_ONE) ? mlp_pkg::Q_ONE : req_bus.target;
      end
   end

   // ---------------- weight RAM ----------------
   always_comb begin
      upd = s2_vld_ff && (s2_op_ff == mlp_pkg::OP_UB || s2_op_ff == mlp_pkg::OP_UW_H ||
                          s2_op_ff == mlp_pkg::OP_UW_A || s2_op_ff == mlp_pkg::OP_UW_B);
      if (upd) begin
         wr_en   = 1'b1;
         wr_addr = s2_addr_ff;
         wr_data = new_w;
      end else begin
         wr_en   = req_acc && (req_bus.req_type == mlp_pkg::REQ_WRITE) &&
                   (32'(req_bus.weight_index) < mlp_pkg::STORE_DEPTH);
         wr_addr = mlp_pkg::ADDR_W'(req_bus.weight_index);
         wr_data = req_bus.weight_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[iss_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         rdv_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         rdv_ff <= vld_ff[iss_addr];
      end
   end
   assign w1 = rdv_ff ? rd_ff : '0;

   // ---------------- stage 1: shared multiplier ----------------
   assign err = $signed({1'b0, tgt_ff}) - $signed({1'b0, out_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (s1_op_ff)
         mlp_pkg::OP_HW0: begin
            mul_a = mlp_pkg::MA_W'(xa_ff);
            mul_b = mlp_pkg::MB_W'(w1);
         end
         mlp_pkg::OP_HW1: begin
            mul_a = mlp_pkg::MA_W'(xb_ff);
            mul_b = mlp_pkg::MB_W'(w1);
         end
         mlp_pkg::OP_OW: begin
            mul_a = mlp_pkg::MA_W'(h_ff[s1_j_ff]);
            mul_b = mlp_pkg::MB_W'(w1);
         end
         mlp_pkg::OP_DO1: begin
            mul_a = mlp_pkg::MA_W'(out_ff);
            mul_b = mlp_pkg::MB_W'(mlp_pkg::Q_ONE - out_ff);
         end
         mlp_pkg::OP_DO2: begin
            mul_a = mlp_pkg::MA_W'(err);
            mul_b = mlp_pkg::MB_W'(dso_ff);
         end
         mlp_pkg::OP_DH0: begin
            mul_a = mlp_pkg::MA_W'(h_ff[s1_j_ff]);
            mul_b = mlp_pkg::MB_W'(mlp_pkg::Q_ONE - h_ff[s1_j_ff]);
         end
         mlp_pkg::OP_DH1: begin
            mul_a = mlp_pkg::MA_W'(dout_ff);
            mul_b = mlp_pkg::MB_W'(w1);
         end
         mlp_pkg::OP_DH2: begin
            mul_a = tmp_ff;
            mul_b = mlp_pkg::MB_W'(dsh_ff);
         end
         mlp_pkg::OP_LR_O: begin
            mul_a = mlp_pkg::MA_W'(dout_ff);
            mul_b = mlp_pkg::MB_W'(lr_c);
         end
         mlp_pkg::OP_LR_H: begin
            mul_a = mlp_pkg::MA_W'(dhid_ff[s1_j_ff]);
            mul_b = mlp_pkg::MB_W'(lr_c);
         end
         mlp_pkg::OP_UW_H: begin
            mul_a = dlr_ff;
            mul_b = mlp_pkg::MB_W'(h_ff[s1_j_ff]);
         end
         mlp_pkg::OP_UW_A: begin
            mul_a = dlr_ff;
            mul_b = mlp_pkg::MB_W'(xa_ff);
         end
         mlp_pkg::OP_UW_B: begin
            mul_a = dlr_ff;
            mul_b = mlp_pkg::MB_W'(xb_ff);
         end
         default: ;
      endcase
   end

   assign prod_in = mlp_pkg::PROD_W'(mul_a) * mlp_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      s1_op_ff   <= iss_op;
      s1_j_ff    <= j_ff;
      s1_addr_ff <= iss_addr;
      s2_op_ff   <= s1_op_ff;
      s2_j_ff    <= s1_j_ff;
      s2_addr_ff <= s1_addr_ff;
      s2_w_ff    <= w1;
      prod_ff    <= prod_in;
   end

   // ---------------- stage 2: accumulate, activate, update ----------------
   assign acc_sh    = acc_ff >>> 12;
   assign z         = acc_sh[mlp_pkg::Z_W-1:0] + mlp_pkg::Z_W'(s2_w_ff);
   assign prod_sh12 = prod_ff >>> 12;
   assign prod_sh24 = prod_ff >>> 24;
   assign dlr_sh    = dlr_ff >>> 12;

   mlp_sig u_sig (
      .z   (z),
      .act (sig_act)
   );

   always_comb begin
      step  = (s2_op_ff == mlp_pkg::OP_UB) ? dlr_sh[mlp_pkg::SUM_W-1:0]
                                           : prod_sh24[mlp_pkg::SUM_W-1:0];
      wsum  = mlp_pkg::SUM_W'(s2_w_ff) + step;
      clip  = 1'b0;
      new_w = wsum[mlp_pkg::W_W-1:0];
      if (wsum > mlp_pkg::W_MAX) begin
         new_w = mlp_pkg::W_W'(mlp_pkg::W_MAX);
         clip  = 1'b1;
      end else if (wsum < mlp_pkg::W_MIN) begin
         new_w = mlp_pkg::W_W'(mlp_pkg::W_MIN);
         clip  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         case (s2_op_ff)
            mlp_pkg::OP_HW0: acc_ff <= prod_ff[mlp_pkg::ACC_W-1:0];
            mlp_pkg::OP_HW1: acc_ff <= acc_ff + prod_ff[mlp_pkg::ACC_W-1:0];
            mlp_pkg::OP_OW: begin
               if (s2_j_ff == '0) acc_ff <= prod_ff[mlp_pkg::ACC_W-1:0];
               else acc_ff <= acc_ff + prod_ff[mlp_pkg::ACC_W-1:0];
            end
            mlp_pkg::OP_HB:   h_ff[s2_j_ff] <= sig_act;
            mlp_pkg::OP_OB:   out_ff <= sig_act;
            mlp_pkg::OP_DO1:  dso_ff <= prod_ff[12 +: mlp_pkg::DS_W];
            mlp_pkg::OP_DO2:  dout_ff <= prod_sh12[mlp_pkg::DOUT_W-1:0];
            mlp_pkg::OP_DH0:  dsh_ff <= prod_ff[12 +: mlp_pkg::DS_W];
            mlp_pkg::OP_DH1:  tmp_ff <= prod_ff[31:0];
            mlp_pkg::OP_DH2:  dhid_ff[s2_j_ff] <= prod_sh24[mlp_pkg::DH_W-1:0];
            mlp_pkg::OP_LR_O: dlr_ff <= prod_ff[mlp_pkg::DLR_W-1:0];
            mlp_pkg::OP_LR_H: dlr_ff <= prod_ff[mlp_pkg::DLR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_ff <= 1'b0;
      end else if (req_acc) begin
         sat_ff <= 1'b0;
      end else if (upd && clip) begin
         sat_ff <= 1'b1;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (res_load) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_out_ff <= (type_ff == mlp_pkg::REQ_INFER || type_ff == mlp_pkg::REQ_TRAIN)
                       ? out_ff : '0;
         rsp_sat_ff <= (type_ff == mlp_pkg::REQ_TRAIN) && sat_ff;
      end
   end

   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.net_output = rsp_out_ff;
   assign rsp_bus.saturated  = rsp_sat_ff;

   // ---------------- assertions ----------------
   `MLP_ASSERT_IMP(a_idle_drained, clock, reset, state_ff == mlp_pkg::ST_IDLE, !pipe_busy)
   `MLP_ASSERT_IMP(a_upd_not_on_accept, clock, reset, upd, !req_acc)
   `MLP_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_acc, state_ff != mlp_pkg::ST_IDLE)
   `MLP_ASSERT_IMP(a_load_only_drained, clock, reset, res_load, !s1_vld_ff && !s2_vld_ff)

endmodule
`default_nettype wire

// File: verif/mlp_sgd_backprop_trainer_test.sv
// Self-checking testbench for the two-layer sigmoid perceptron trainer.
// Uses mlp_pkg and the mlp_req_if / mlp_rsp_if channel interfaces; holds its own
// fixed-point model of the network and the weight store to predict every result.
`default_nettype none
module mlp_sgd_backprop_trainer_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mlp_pkg::*;

   typedef struct {
      logic [TYPE_W-1:0]        kind;
      logic [ACT_W-1:0]         a;
      logic [ACT_W-1:0]         b;
      logic [ACT_W-1:0]         tgt;
      logic [WIDX_W-1:0]        idx;
      logic signed [W_W-1:0]    val;
   } net_req_t;

   typedef struct {
      logic [ACT_W-1:0] net;
      logic             sat;
   } net_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   mlp_req_if req_ch();
   mlp_rsp_if rsp_ch();

   mlp_sgd_backprop_trainer u_dut (
      .clock(clock), .reset(reset), .req_bus(req_ch), .rsp_bus(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // network model state
   longint     weights [STORE_DEPTH];
   longint     hid_act [HIDDEN_NODES];
   longint     sig_lut [SIG_DEPTH];
   logic [LR_W-1:0] rate_reg;

   net_req_t   pending_reqs [$];
   net_rsp_t   expected_rsps [$];
   net_req_t   cur_req;
   int         req_gap = 0;
   int         rsp_stall = 0;
   int         idle_cycles = 0;
   int         err_cnt = 0;
   bit         quiet = 1'b0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_INFER;
      req_ch.in_a = '0;
      req_ch.in_b = '0;
      req_ch.target = '0;
      req_ch.weight_index = '0;
      req_ch.weight_value = '0;
      rsp_ch.ready = 1'b0;
   end

   // sigmoid at Q8.12 point x: series for exp(-frac), then 1/e per integer step
   function automatic longint sig_value(longint x);
      longint unsigned t, n, f, term, e, den, k;
      longint sum;
      t = (x < 0) ? -x : x;
      n = t >> 12;
      f = t & 64'd4095;
      term = 64'd1 << 30;
      sum = 64'sd1 << 30;
      for (k = 1; k <= 12; k++) begin
         term = term * f / (64'd4096 * k);
         if (k[0]) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      e = sum;
      for (k = 0; k < n; k++) e = (e * 64'd395007542) >> 30;
      den = (64'd1 << 30) + e;
      if (x >= 0) return ((64'd4096 << 30) + den / 2) / den;
      return (64'd4096 * e + den / 2) / den;
   endfunction

   function automatic longint act_lookup(longint z);
      if (z < -32768) z = -32768;
      if (z > 32767) z = 32767;
      return sig_lut[((z + 32768) * SIG_DEPTH) >>> 16];
   endfunction

   function automatic longint clip_q12(logic [ACT_W-1:0] v);
      return (v > Q_ONE) ? 4096 : longint'(v);
   endfunction

   function automatic longint slope(longint a);
      return (a * (4096 - a)) >>> 12;
   endfunction

   function automatic void bump_weight(int k, longint step, ref bit sat);
      longint v;
      v = weights[k] + step;
      if (v > W_MAX) begin
         v = W_MAX;
         sat = 1'b1;
      end
      if (v < W_MIN) begin
         v = W_MIN;
         sat = 1'b1;
      end
      weights[k] = v;
   endfunction

   function automatic net_rsp_t predict_step(net_req_t it);
      net_rsp_t r;
      longint xa, xb, tg, acc, outa, lr, d_o;
      longint d_h [HIDDEN_NODES];
      bit sat;
      r.net = '0;
      r.sat = 1'b0;
      sat = 1'b0;
      if (it.kind == REQ_WRITE) begin
         if (it.idx < STORE_DEPTH) weights[it.idx] = longint'(it.val);
         return r;
      end
      if (it.kind == REQ_RSVD) return r;
      xa = clip_q12(it.a);
      xb = clip_q12(it.b);
      tg = clip_q12(it.tgt);
      for (int j = 0; j < HIDDEN_NODES; j++) begin
         acc = xa * weights[j] + xb * weights[OFS_IN_B + j];
         hid_act[j] = act_lookup(weights[OFS_HB + j] + (acc >>> 12));
      end
      acc = 0;
      for (int j = 0; j < HIDDEN_NODES; j++) acc += hid_act[j] * weights[OFS_OUT + j];
      outa = act_lookup(weights[OFS_OB] + (acc >>> 12));
      r.net = outa[ACT_W-1:0];
      if (it.kind == REQ_TRAIN) begin
         lr = clip_q12(rate_reg);
         d_o = ((tg - outa) * slope(outa)) >>> 12;
         for (int j = 0; j < HIDDEN_NODES; j++)
            d_h[j] = (d_o * weights[OFS_OUT + j] * slope(hid_act[j])) >>> 24;
         bump_weight(OFS_OB, (d_o * lr) >>> 12, sat);
         for (int j = 0; j < HIDDEN_NODES; j++)
            bump_weight(OFS_OUT + j, (hid_act[j] * d_o * lr) >>> 24, sat);
         for (int j = 0; j < HIDDEN_NODES; j++) begin
            bump_weight(OFS_HB + j, (d_h[j] * lr) >>> 12, sat);
            bump_weight(j, (xa * d_h[j] * lr) >>> 24, sat);
            bump_weight(OFS_IN_B + j, (xb * d_h[j] * lr) >>> 24, sat);
         end
         r.sat = sat;
      end
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_reqs
      net_req_t nxt;
      bit hold;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap <= 0;
      end else begin
         hold = 1'b0;
         if (req_ch.valid && req_ch.ready) expected_rsps.push_back(predict_step(cur_req));
         else if (req_ch.valid) hold = 1'b1;
         if (!hold) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               nxt = pending_reqs.pop_front();
               cur_req = nxt;
               req_ch.req_type <= nxt.kind;
               req_ch.in_a <= nxt.a;
               req_ch.in_b <= nxt.b;
               req_ch.target <= nxt.tgt;
               req_ch.weight_index <= nxt.idx;
               req_ch.weight_value <= nxt.val;
               req_ch.valid <= 1'b1;
               if (!quiet && $urandom_range(0, 3) == 0) req_gap <= $urandom_range(1, 15);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // result checker, receiver stalls and watchdog
   always @(posedge clock) begin : check_rsps
      net_rsp_t exp_r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result beat net_output=%0d saturated=%0d",
                        $realtime, rsp_ch.net_output, rsp_ch.saturated);
               err_cnt++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_ch.net_output !== exp_r.net) begin
                  $display("%0t: net_output mismatch expected %0d actual %0d",
                           $realtime, exp_r.net, rsp_ch.net_output);
                  err_cnt++;
               end
               if (rsp_ch.saturated !== exp_r.sat) begin
                  $display("%0t: saturated mismatch expected %0d actual %0d",
                           $realtime, exp_r.sat, rsp_ch.saturated);
                  err_cnt++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0) rsp_stall <= $urandom_range(1, 15);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 3000) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $realtime, expected_rsps.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic set_rate(logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(4 * CSR_LEARN_RATE);
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      rate_reg = v[LR_W-1:0];
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_write(int k, longint v);
      net_req_t it;
      it.kind = REQ_WRITE;
      it.a = ACT_W'($urandom());
      it.b = ACT_W'($urandom());
      it.tgt = ACT_W'($urandom());
      it.idx = WIDX_W'(k);
      it.val = W_W'(v);
      pending_reqs.push_back(it);
   endtask

   task automatic push_run(logic [TYPE_W-1:0] kind, longint a, longint b, longint t);
      net_req_t it;
      it.kind = kind;
      it.a = ACT_W'(a);
      it.b = ACT_W'(b);
      it.tgt = ACT_W'(t);
      it.idx = WIDX_W'($urandom());
      it.val = W_W'($urandom());
      pending_reqs.push_back(it);
   endtask

   function automatic longint rand_weight();
      case ($urandom_range(0, 7))
         0: return W_MAX;
         1: return W_MIN;
         2: return longint'($signed(W_W'($urandom())));
         default: return longint'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic longint rand_act();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 4096;
         2: return longint'(ACT_W'($urandom()));
         default: return $urandom_range(0, 4096);
      endcase
   endfunction

   task automatic random_phase(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 3) begin
            if ($urandom_range(0, 9) == 0) push_write($urandom_range(0, 31), rand_weight());
            else push_write($urandom_range(0, STORE_DEPTH - 1), rand_weight());
         end else if (r == 3 && $urandom_range(0, 1) == 0) begin
            push_run(REQ_RSVD, $urandom(), $urandom(), $urandom());
         end else if (r < 9) begin
            push_run(REQ_INFER, rand_act(), rand_act(), rand_act());
         end else begin
            push_run(REQ_TRAIN, rand_act(), rand_act(), rand_act());
         end
      end
   endtask

   initial begin
      for (int i = 0; i < SIG_DEPTH; i++)
         sig_lut[i] = sig_value(-32768 + longint'((2 * i + 1) * 32768 / SIG_DEPTH));
      for (int k = 0; k < STORE_DEPTH; k++) weights[k] = 0;
      for (int j = 0; j < HIDDEN_NODES; j++) hid_act[j] = 0;
      rate_reg = 410;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: default rate, zero store, input extremes and odd encodings
      push_run(REQ_INFER, 0, 0, 0);
      push_run(REQ_INFER, 4096, 4096, 0);
      push_run(REQ_INFER, 8191, 8191, 8191);
      push_run(REQ_RSVD, 4096, 4096, 4096);
      push_write(31, W_MAX);
      push_write(STORE_DEPTH, W_MIN);
      push_run(REQ_TRAIN, 4096, 0, 0);
      push_run(REQ_TRAIN, 0, 4096, 8191);
      // pre-activation far beyond the table on both sides
      push_write(0, W_MAX);
      push_write(HIDDEN_NODES, W_MIN);
      push_run(REQ_INFER, 4096, 0, 0);
      push_run(REQ_INFER, 0, 4096, 0);
      push_write(OFS_OB, W_MIN);
      push_run(REQ_TRAIN, 4096, 4096, 4096);
      wait_idle();

      // an output weight pinned near the top must clip on a strong update
      set_rate(4096);
      for (int k = 0; k < STORE_DEPTH; k++) push_write(k, 0);
      push_write(OFS_OUT, W_MAX - 5);
      push_write(OFS_OUT + 1, W_MIN + 5);
      push_run(REQ_TRAIN, 2048, 1024, 4096);
      push_run(REQ_TRAIN, 4096, 4096, 0);
      wait_idle();

      set_rate(0);
      random_phase(150);
      wait_idle();
      set_rate(8191);
      random_phase(150);
      wait_idle();
      set_rate($urandom_range(1, 4095));
      random_phase(150);
      wait_idle();
      set_rate(410);
      quiet = 1'b1;
      random_phase(150);

      wait (pending_reqs.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
      repeat (120) @(posedge clock);
      if (err_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
